[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high
`define GPRS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Concurrent check that also holds across reset
`define GPRS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

[rtl/gprs_pkg.sv]
// ---------------------------------------------------------------------------
// gprs_pkg
// Types, register codes and helpers of the GPE right-hand-side stencil.
// ---------------------------------------------------------------------------
`default_nettype none

package gprs_pkg;

   // register indexes on the control port
   localparam logic [2:0] CSR_GRID_COLS = 3'd0;
   localparam logic [2:0] CSR_GRID_ROWS = 3'd1;
   localparam logic [2:0] CSR_COEF_X    = 3'd2;
   localparam logic [2:0] CSR_COEF_Y    = 3'd3;
   localparam logic [2:0] CSR_COUPLING  = 3'd4;

   localparam logic [39:0] K_MAX = 40'h7F_FFFF_FFFF;
   localparam logic [39:0] K_MIN = 40'h80_0000_0000;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [10:0]        grid_cols;
      logic [15:0]        grid_rows;
      logic [31:0]        coef_x;
      logic [31:0]        coef_y;
      logic signed [31:0] coupling;
   } gprs_cfg_type;

   // one classified grid point handed from front to back
   typedef struct packed {
      logic               is_int;
      logic               is_bnd;
      logic signed [25:0] lxr;
      logic signed [25:0] lxi;
      logic signed [25:0] lyr;
      logic signed [25:0] lyi;
      logic signed [23:0] ctr_re;
      logic signed [23:0] ctr_im;
      logic signed [23:0] cur_re;
      logic signed [23:0] cur_im;
      logic [15:0]        row;
      logic [9:0]         col;
   } gprs_task_type;

   // clamp a signed value to the 40-bit result range
   function automatic logic [39:0] sat_k(input logic signed [48:0] v);
      logic same;
      same = (v[48:39] == 10'h000) || (v[48:39] == 10'h3FF);
      if (same) return v[39:0];
      else if (v[48]) return K_MIN;
      else return K_MAX;
   endfunction

endpackage

`default_nettype wire

[rtl/gprs_ram.sv]
// ---------------------------------------------------------------------------
// gprs_ram
// Generic RAM, one write port and two registered read ports.
// ---------------------------------------------------------------------------
`default_nettype none

module gprs_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

[rtl/gprs_front.sv]
// ---------------------------------------------------------------------------
// gprs_front
// Tracks the raster position, reads and updates the line RAM, classifies
// each sample and forms the second differences for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module gprs_front #(
   parameter int MAX_COLS    = 1024,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire gprs_pkg::gprs_cfg_type    cfg,
   input  wire logic                      push,
   output logic                           full,
   input  wire logic [SAMPLE_BITS-1:0]    psi_re,
   input  wire logic [SAMPLE_BITS-1:0]    psi_im,
   input  wire logic                      frame_start,
   input  wire logic                      q_full,
   output logic                           q_push,
   output gprs_pkg::gprs_task_type        q_data
);
   import gprs_pkg::*;

   localparam int CW = $clog2(MAX_COLS + 1);
   localparam int AW = $clog2(MAX_COLS);

   typedef enum logic {S_IDLE, S_WRITE} fstate_type;

   fstate_type         state_ff;
   logic [CW-1:0]      col_ff;
   logic [15:0]        row_ff;
   logic [CW-1:0]      item_col_ff;
   logic [15:0]        item_row_ff;
   logic               item_int_ff;
   logic               item_bnd_ff;
   logic [47:0]        cur_ff;
   logic [47:0]        left_ff;

   logic [CW-1:0]      cols;
   logic [15:0]        rows;
   logic [CW-1:0]      cc;
   logic [15:0]        rr;
   logic [CW:0]        c1;
   logic [16:0]        r1;
   logic               accept;
   logic               is_int;
   logic               is_bnd;
   logic [CW-1:0]      col_in;
   logic [15:0]        row_in;
   logic [SAMPLE_BITS+23:0] wide_re;
   logic [SAMPLE_BITS+23:0] wide_im;
   logic [47:0]        cur_in;
   logic [95:0]        rd_a;
   logic [95:0]        rd_b;
   logic [47:0]        up;
   logic [47:0]        ctr;
   logic [47:0]        right;

   assign accept = push && !full;
   assign full   = (state_ff != S_IDLE) || q_full;

   // clamp grid size
   always_comb begin
      if (cfg.grid_cols < 11'd3) cols = CW'(3);
      else if (32'(cfg.grid_cols) > MAX_COLS) cols = CW'(MAX_COLS);
      else cols = CW'(cfg.grid_cols);
      rows = (cfg.grid_rows < 16'd3) ? 16'd3 : cfg.grid_rows;
   end

   // place the arriving sample and classify it
   always_comb begin
      if (frame_start) begin
         cc = '0;
         rr = '0;
      end else begin
         cc = col_ff;
         rr = row_ff;
         if (cc >= cols) begin
            cc = '0;
            rr = rr + 16'd1;
         end
         if (rr >= rows) rr = '0;
      end
      c1 = {1'b0, cc} + (CW+1)'(1);
      r1 = {1'b0, rr} + 17'd1;
      is_int = (rr >= 16'd2) && (cc != '0) && (({1'b0, cc} + (CW+1)'(2)) <= {1'b0, cols});
      is_bnd = (rr == 16'd0) || (r1 == {1'b0, rows}) || (cc == '0) || (c1 == {1'b0, cols});
      if (c1 >= {1'b0, cols}) begin
         col_in = '0;
         row_in = (r1 >= {1'b0, rows}) ? 16'd0 : r1[15:0];
      end else begin
         col_in = c1[CW-1:0];
         row_in = rr;
      end
   end

   // align samples to Q4.20
   assign wide_re = {psi_re, 24'b0};
   assign wide_im = {psi_im, 24'b0};
   assign cur_in  = {wide_re[SAMPLE_BITS+23:SAMPLE_BITS], wide_im[SAMPLE_BITS+23:SAMPLE_BITS]};

   // line RAM: upper line in the high half, middle line in the low half
   gprs_ram #(.WIDTH(96), .DEPTH(MAX_COLS)) u_line (
      .clock     (clock),
      .wr_en     (state_ff == S_WRITE),
      .wr_addr   (item_col_ff[AW-1:0]),
      .wr_data   ({ctr, cur_ff}),
      .rd_addr_a (cc[AW-1:0]),
      .rd_data_a (rd_a),
      .rd_addr_b (c1[AW-1:0]),
      .rd_data_b (rd_b)
   );

   assign up    = rd_a[95:48];
   assign ctr   = rd_a[47:0];
   assign right = rd_b[47:0];

   // form the task from the neighbors
   always_comb begin
      q_data.is_int = item_int_ff;
      q_data.is_bnd = item_bnd_ff;
      q_data.lxr = {{2{up[47]}}, up[47:24]} + {{2{cur_ff[47]}}, cur_ff[47:24]}
                 - {ctr[47], ctr[47:24], 1'b0};
      q_data.lxi = {{2{up[23]}}, up[23:0]} + {{2{cur_ff[23]}}, cur_ff[23:0]}
                 - {ctr[23], ctr[23:0], 1'b0};
      q_data.lyr = {{2{left_ff[47]}}, left_ff[47:24]} + {{2{right[47]}}, right[47:24]}
                 - {ctr[47], ctr[47:24], 1'b0};
      q_data.lyi = {{2{left_ff[23]}}, left_ff[23:0]} + {{2{right[23]}}, right[23:0]}
                 - {ctr[23], ctr[23:0], 1'b0};
      q_data.ctr_re = ctr[47:24];
      q_data.ctr_im = ctr[23:0];
      q_data.cur_re = cur_ff[47:24];
      q_data.cur_im = cur_ff[23:0];
      q_data.row    = item_row_ff;
      q_data.col    = 10'(item_col_ff);
   end

   assign q_push = (state_ff == S_WRITE) && (item_int_ff || item_bnd_ff);

   // take a beat, then write the line back
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         left_ff  <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  col_ff   <= col_in;
                  row_ff   <= row_in;
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               left_ff  <= ctr;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // hold the accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         item_col_ff <= cc;
         item_row_ff <= rr;
         item_int_ff <= is_int;
         item_bnd_ff <= is_bnd;
         cur_ff      <= cur_in;
      end
   end

endmodule

`default_nettype wire

[rtl/gprs_queue.sv]
// ---------------------------------------------------------------------------
// gprs_queue
// Short task queue between the front and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module gprs_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire gprs_pkg::gprs_task_type data_in,
   output logic                         full,
   input  wire logic                    pop,
   output logic                         empty,
   output gprs_pkg::gprs_task_type      data_out
);
   import gprs_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   gprs_task_type   slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW:0]     count_ff;
   logic            do_push;
   logic            do_pop;

   assign full     = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = slot_ff[rd_ptr_ff];

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + PW'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + PW'(1);
         if (do_push && !do_pop) count_ff <= count_ff + (PW+1)'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= data_in;
   end

endmodule

`default_nettype wire

[rtl/gprs_back.sv]
// ---------------------------------------------------------------------------
// gprs_back
// Runs the Laplacian and nonlinear products on one shared multiplier and
// holds each result in an output register until it is popped.
// ---------------------------------------------------------------------------
`default_nettype none

module gprs_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire gprs_pkg::gprs_cfg_type  cfg,
   input  wire logic                    task_valid,
   input  wire gprs_pkg::gprs_task_type task_in,
   output logic                         task_pop,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output logic [39:0]                  rsp_k_re,
   output logic [39:0]                  rsp_k_im,
   output logic [15:0]                  rsp_out_row,
   output logic [9:0]                   rsp_out_col,
   output logic                         rsp_last_of_item
);
   import gprs_pkg::*;

   typedef enum logic [1:0] {B_IDLE, B_MUL, B_ACC, B_OUT} bstate_type;

   typedef enum logic [3:0] {
      ST_LXR, ST_LYR, ST_LXI, ST_LYI, ST_RR, ST_II, ST_GN,
      ST_HR, ST_LR, ST_HI, ST_LI
   } step_type;

   bstate_type          state_ff;
   step_type            step_ff;
   gprs_task_type       task_ff;
   logic                phase_bnd_ff;
   logic signed [23:0]  pt_re_ff;
   logic signed [23:0]  pt_im_ff;
   logic [15:0]         row_ff;
   logic signed [63:0]  prod_ff;
   logic signed [63:0]  acc_ff;
   logic signed [47:0]  lap_re_ff;
   logic signed [47:0]  lap_im_ff;
   logic [27:0]         n20_ff;
   logic signed [43:0]  gn_ff;
   logic signed [47:0]  nr_ff;
   logic signed [47:0]  ni_ff;
   logic                out_valid_ff;
   logic [39:0]         k_re_ff;
   logic [39:0]         k_im_ff;
   logic [15:0]         out_row_ff;
   logic [9:0]          out_col_ff;
   logic                out_last_ff;

   logic signed [33:0]  op_a;
   logic signed [29:0]  op_b;
   logic signed [63:0]  mul_full;
   logic signed [63:0]  acc_sum;
   logic signed [63:0]  q20_sum;
   logic signed [48:0]  dk_re;
   logic signed [48:0]  dk_im;
   logic                out_free;
   logic                out_load;

   assign task_pop         = (state_ff == B_IDLE) && task_valid;
   assign out_free         = !out_valid_ff || rsp_pop;
   assign out_load         = (state_ff == B_OUT) && out_free;
   assign rsp_empty        = !out_valid_ff;
   assign rsp_k_re         = k_re_ff;
   assign rsp_k_im         = k_im_ff;
   assign rsp_out_row      = out_row_ff;
   assign rsp_out_col      = out_col_ff;
   assign rsp_last_of_item = out_last_ff;

   // select multiplier operands per step
   always_comb begin
      case (step_ff)
         ST_LXR: begin op_a = {2'b0, cfg.coef_x};  op_b = 30'(task_ff.lxr); end
         ST_LYR: begin op_a = {2'b0, cfg.coef_y};  op_b = 30'(task_ff.lyr); end
         ST_LXI: begin op_a = {2'b0, cfg.coef_x};  op_b = 30'(task_ff.lxi); end
         ST_LYI: begin op_a = {2'b0, cfg.coef_y};  op_b = 30'(task_ff.lyi); end
         ST_RR:  begin op_a = 34'(pt_re_ff);        op_b = 30'(pt_re_ff); end
         ST_II:  begin op_a = 34'(pt_im_ff);        op_b = 30'(pt_im_ff); end
         ST_GN:  begin op_a = 34'(cfg.coupling);    op_b = {2'b0, n20_ff}; end
         ST_HR:  begin op_a = 34'($signed(gn_ff[43:20])); op_b = 30'(pt_re_ff); end
         ST_LR:  begin op_a = {14'b0, gn_ff[19:0]}; op_b = 30'(pt_re_ff); end
         ST_HI:  begin op_a = 34'($signed(gn_ff[43:20])); op_b = 30'(pt_im_ff); end
         ST_LI:  begin op_a = {14'b0, gn_ff[19:0]}; op_b = 30'(pt_im_ff); end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   assign mul_full = op_a * op_b;
   assign acc_sum  = acc_ff + prod_ff;
   assign q20_sum  = acc_ff + (prod_ff >>> 20);
   assign dk_re    = {ni_ff[47], ni_ff} - {lap_im_ff[47], lap_im_ff};
   assign dk_im    = {lap_re_ff[47], lap_re_ff} - {nr_ff[47], nr_ff};

   // step sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         step_ff      <= ST_LXR;
         phase_bnd_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_load || (out_valid_ff && !rsp_pop);
         case (state_ff)
            B_IDLE: begin
               if (task_valid) begin
                  task_ff <= task_in;
                  if (task_in.is_int) begin
                     pt_re_ff     <= task_in.ctr_re;
                     pt_im_ff     <= task_in.ctr_im;
                     row_ff       <= task_in.row - 16'd1;
                     step_ff      <= ST_LXR;
                     phase_bnd_ff <= 1'b0;
                  end else begin
                     pt_re_ff     <= task_in.cur_re;
                     pt_im_ff     <= task_in.cur_im;
                     row_ff       <= task_in.row;
                     lap_re_ff    <= '0;
                     lap_im_ff    <= '0;
                     step_ff      <= ST_RR;
                     phase_bnd_ff <= 1'b1;
                  end
                  state_ff <= B_MUL;
               end
            end
            B_MUL: begin
               prod_ff  <= mul_full;
               state_ff <= B_ACC;
            end
            B_ACC: begin
               case (step_ff)
                  ST_LXR, ST_LXI, ST_RR, ST_HR, ST_HI: acc_ff <= prod_ff;
                  ST_LYR: lap_re_ff <= acc_sum[63:16];
                  ST_LYI: lap_im_ff <= acc_sum[63:16];
                  ST_II:  n20_ff    <= acc_sum[47:20];
                  ST_GN:  gn_ff     <= prod_ff[59:16];
                  ST_LR:  nr_ff     <= q20_sum[47:0];
                  ST_LI:  ni_ff     <= q20_sum[47:0];
                  default: acc_ff   <= prod_ff;
               endcase
               if (step_ff == ST_LI) begin
                  state_ff <= B_OUT;
               end else begin
                  step_ff  <= step_type'(step_ff + 4'd1);
                  state_ff <= B_MUL;
               end
            end
            B_OUT: begin
               if (out_free) begin
                  k_re_ff      <= sat_k(dk_re);
                  k_im_ff      <= sat_k(dk_im);
                  out_row_ff   <= row_ff;
                  out_col_ff   <= task_ff.col;
                  out_last_ff  <= phase_bnd_ff || !task_ff.is_bnd;
                  if (!phase_bnd_ff && task_ff.is_bnd) begin
                     pt_re_ff     <= task_ff.cur_re;
                     pt_im_ff     <= task_ff.cur_im;
                     row_ff       <= task_ff.row;
                     lap_re_ff    <= '0;
                     lap_im_ff    <= '0;
                     step_ff      <= ST_RR;
                     phase_bnd_ff <= 1'b1;
                     state_ff     <= B_MUL;
                  end else begin
                     state_ff <= B_IDLE;
                  end
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/gpe_real_time_rhs_stencil.sv]
// Accepts a sample only while idle and the queue has room: the line RAM is read,
// then written back, before the next sample is taken. Each result runs its
// products on the shared 34x30 multiplier, each product registered and then
// accumulated; an interior result runs the Laplacian products first.
// Synchronous reset sets positions, queue pointers, sequencers, the result valid
// flag and control registers to their reset values; the line RAM is not cleared.
// ---------------------------------------------------------------------------
// gpe_real_time_rhs_stencil
// Streaming five-point Laplacian plus cubic term for the real-time GPE.
// ---------------------------------------------------------------------------
`default_nettype none

module gpe_real_time_rhs_stencil #(
   parameter int MAX_COLS    = 1024,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [SAMPLE_BITS-1:0] req_psi_re,
   input  wire logic [SAMPLE_BITS-1:0] req_psi_im,
   input  wire logic                   req_frame_start,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [39:0]                 rsp_k_re,
   output logic [39:0]                 rsp_k_im,
   output logic [15:0]                 rsp_out_row,
   output logic [9:0]                  rsp_out_col,
   output logic                        rsp_last_of_item,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [4:0]             csr_paddr,
   input  wire logic [31:0]            csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import gprs_pkg::*;

   gprs_cfg_type   cfg_ff;
   gprs_task_type  q_in;
   gprs_task_type  q_out;
   logic           q_push;
   logic           q_full;
   logic           q_empty;
   logic           q_pop;
   logic           csr_wr;
   logic [2:0]     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_cols <= 11'd64;
         cfg_ff.grid_rows <= 16'd64;
         cfg_ff.coef_x    <= 32'd65536;
         cfg_ff.coef_y    <= 32'd65536;
         cfg_ff.coupling  <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_GRID_COLS: cfg_ff.grid_cols <= csr_pwdata[10:0];
            CSR_GRID_ROWS: cfg_ff.grid_rows <= csr_pwdata[15:0];
            CSR_COEF_X:    cfg_ff.coef_x    <= csr_pwdata;
            CSR_COEF_Y:    cfg_ff.coef_y    <= csr_pwdata;
            CSR_COUPLING:  cfg_ff.coupling  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (csr_idx)
         CSR_GRID_COLS: csr_prdata = {21'b0, cfg_ff.grid_cols};
         CSR_GRID_ROWS: csr_prdata = {16'b0, cfg_ff.grid_rows};
         CSR_COEF_X:    csr_prdata = cfg_ff.coef_x;
         CSR_COEF_Y:    csr_prdata = cfg_ff.coef_y;
         CSR_COUPLING:  csr_prdata = cfg_ff.coupling;
         default:       csr_prdata = '0;
      endcase
   end

   gprs_front #(.MAX_COLS(MAX_COLS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .push        (req_push),
      .full        (req_full),
      .psi_re      (req_psi_re),
      .psi_im      (req_psi_im),
      .frame_start (req_frame_start),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_in)
   );

   gprs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .data_in  (q_in),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .data_out (q_out)
   );

   gprs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .task_valid       (!q_empty),
      .task_in          (q_out),
      .task_pop         (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_k_re         (rsp_k_re),
      .rsp_k_im         (rsp_k_im),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule

`default_nettype wire

[rtl/gprs_checker.sv]
// ---------------------------------------------------------------------------
// gprs_checker
// Port-level checks of the stencil block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gprs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_push,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [39:0] rsp_k_re,
   input wire logic [39:0] rsp_k_im,
   input wire logic [15:0] rsp_out_row,
   input wire logic [9:0]  rsp_out_col,
   input wire logic        csr_pready
);

   logic [105:0] rsp_bits;

   // gather the result payload
   assign rsp_bits = {rsp_k_re, rsp_k_im, rsp_out_row, rsp_out_col};

   // reset leaves no result waiting
   `GPRS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty)

   // an accepted beat blocks the input for the write-back cycle
   `GPRS_ASSERT(a_accept_busy, clock, reset, (req_push && !req_full) |=> req_full)

   // a waiting result holds still until popped
   `GPRS_ASSERT(a_rsp_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_bits)))

   // the control port never waits
   `GPRS_ASSERT(a_pready, clock, reset, !reset |-> csr_pready)

endmodule

bind gpe_real_time_rhs_stencil gprs_checker u_gprs_checker (.*);

`default_nettype wire

[tb/sv/gpe_real_time_rhs_stencil_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GPE right-hand-side stencil testbench
// Streams raster frames of complex samples through the stencil and compares
// every result beat against a cycle-free predictor of the Laplacian plus the
// cubic term. Covers grid size clamping, register extremes and broken frames,
// with random gaps on both the sample and the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module gpe_real_time_rhs_stencil_test;
   import gprs_pkg::*;

   localparam int NCOLS = 1024;
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      logic signed [23:0] re;
      logic signed [23:0] im;
   } sample_type;

   typedef struct {
      logic [39:0] k_re;
      logic [39:0] k_im;
      logic [15:0] row;
      logic [9:0]  col;
      logic        last;
   } k_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [23:0] req_psi_re = '0;
   logic [23:0] req_psi_im = '0;
   logic req_frame_start = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [39:0] rsp_k_re, rsp_k_im;
   logic [15:0] rsp_out_row;
   logic [9:0] rsp_out_col;
   logic rsp_last_of_item;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   gpe_real_time_rhs_stencil DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_psi_re(req_psi_re), .req_psi_im(req_psi_im),
      .req_frame_start(req_frame_start),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_k_re(rsp_k_re), .rsp_k_im(rsp_k_im),
      .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col),
      .rsp_last_of_item(rsp_last_of_item),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   // predictor state and register copies
   sample_type  upper_row [NCOLS];
   sample_type  middle_row [NCOLS];
   sample_type  left_sample;
   int unsigned row_pos, col_pos;
   logic [10:0] grid_cols_reg;
   logic [15:0] grid_rows_reg;
   logic [31:0] coef_x_reg, coef_y_reg, coupling_reg;

   k_beat_type  expected_k [$];
   int          error_count = 0;
   int          items_sent = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int random_gap();
      int p;
      p = $urandom_range(99);
      if (p < 60) return 0;
      if (p < 94) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic logic signed [39:0] sat40(input longint v);
      if (v > 64'sh7F_FFFF_FFFF) return K_MAX;
      if (v < -64'sh80_0000_0000) return K_MIN;
      return v[39:0];
   endfunction

   // floor(a * b / 2^20) without overflowing 64 bits
   function automatic longint mul_q20(input longint a, input longint b);
      longint hi, lo;
      hi = a >>> 20;
      lo = a - (hi <<< 20);
      return hi * b + ((lo * b) >>> 20);
   endfunction

   function automatic k_beat_type gpe_rhs(input longint lap_re, input longint lap_im,
                                          input sample_type p, input int unsigned r,
                                          input int unsigned c);
      k_beat_type b;
      longint pr, pi, n20, gn, nr, ni;
      pr = p.re;
      pi = p.im;
      n20 = (pr * pr + pi * pi) >>> 20;
      gn = (longint'($signed(coupling_reg)) * n20) >>> 16;
      nr = mul_q20(gn, pr);
      ni = mul_q20(gn, pi);
      b.k_re = sat40(ni - lap_im);
      b.k_im = sat40(lap_re - nr);
      b.row = r[15:0];
      b.col = c[9:0];
      b.last = 1'b0;
      return b;
   endfunction

   // advance the raster position and queue the results of one accepted sample
   task automatic predict_stencil(input sample_type cur, input logic fs);
      int unsigned cols, rows, r, c, n;
      sample_type up, ctr, right;
      longint cx, cy, lxr, lxi, lyr, lyi;
      k_beat_type b;
      cols = grid_cols_reg < 3 ? 3 : (grid_cols_reg > NCOLS ? NCOLS : grid_cols_reg);
      rows = grid_rows_reg < 3 ? 3 : grid_rows_reg;
      if (fs) begin
         row_pos = 0;
         col_pos = 0;
      end else begin
         if (col_pos >= cols) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= rows) row_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      up = upper_row[c];
      ctr = middle_row[c];
      right = '{0, 0};
      if (c + 1 < NCOLS) right = middle_row[c + 1];
      n = 0;
      if (r >= 2 && c >= 1 && c + 2 <= cols) begin
         cx = coef_x_reg;
         cy = coef_y_reg;
         lxr = longint'(up.re) + cur.re - 2 * longint'(ctr.re);
         lxi = longint'(up.im) + cur.im - 2 * longint'(ctr.im);
         lyr = longint'(left_sample.re) + right.re - 2 * longint'(ctr.re);
         lyi = longint'(left_sample.im) + right.im - 2 * longint'(ctr.im);
         expected_k.push_back(gpe_rhs((cx * lxr + cy * lyr) >>> 16,
                                      (cx * lxi + cy * lyi) >>> 16, ctr, r - 1, c));
         n++;
      end
      if (r == 0 || r + 1 == rows || c == 0 || c + 1 == cols) begin
         expected_k.push_back(gpe_rhs(0, 0, cur, r, c));
         n++;
      end
      if (n > 0) begin
         b = expected_k.pop_back();
         b.last = 1'b1;
         expected_k.push_back(b);
      end
      left_sample = ctr;
      upper_row[c] = ctr;
      middle_row[c] = cur;
      col_pos = c + 1;
      if (col_pos >= cols) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= rows) row_pos = 0;
      end
   endtask

   // send one sample beat after a random gap
   task automatic send_sample(input logic [23:0] re, input logic [23:0] im,
                              input logic fs);
      sample_type s;
      repeat (random_gap()) begin
         @(negedge clock);
         req_push = 1'b0;
      end
      @(negedge clock);
      req_push = 1'b1;
      req_psi_re = re;
      req_psi_im = im;
      req_frame_start = fs;
      do @(posedge clock); while (req_full);
      s.re = re;
      s.im = im;
      predict_stencil(s, fs);
      items_sent++;
   endtask

   function automatic logic [23:0] random_sample();
      int p;
      p = $urandom_range(99);
      if (p < 10) return 24'h7FFFFF;
      if (p < 20) return 24'h800000;
      if (p < 50) return 24'($signed($urandom_range(4095)) - 2048);
      return 24'($urandom());
   endfunction

   // hold the stream until every result is in and the pipeline has drained
   task automatic wait_drained();
      @(negedge clock);
      req_push = 1'b0;
      while (expected_k.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = {index, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         CSR_GRID_COLS: grid_cols_reg = value[10:0];
         CSR_GRID_ROWS: grid_rows_reg = value[15:0];
         CSR_COEF_X:    coef_x_reg = value;
         CSR_COEF_Y:    coef_y_reg = value;
         CSR_COUPLING:  coupling_reg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic set_grid(input logic [31:0] cols, input logic [31:0] rows,
                           input logic [31:0] cx, input logic [31:0] cy,
                           input logic [31:0] g);
      write_csr(CSR_GRID_COLS, cols);
      write_csr(CSR_GRID_ROWS, rows);
      write_csr(CSR_COEF_X, cx);
      write_csr(CSR_COEF_Y, cy);
      write_csr(CSR_COUPLING, g);
   endtask

   // one frame of random samples, frame_start on the first beat
   task automatic send_frame(input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         send_sample(random_sample(), random_sample(), i == 0);
   endtask

   // smallest grid, extreme samples, saturating coefficients
   task automatic test_directed_extremes();
      set_grid(3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_sample(24'h7FFFFF, 24'h800000, 1'b1);
      send_sample(24'h800000, 24'h7FFFFF, 1'b0);
      send_sample(24'h000000, 24'h000000, 1'b0);
      send_sample(24'h800000, 24'h800000, 1'b0);
      send_sample(24'h7FFFFF, 24'h7FFFFF, 1'b0);
      send_sample(24'h800000, 24'h800000, 1'b0);
      send_sample(24'h000001, 24'hFFFFFF, 1'b0);
      send_sample(24'h7FFFFF, 24'h7FFFFF, 1'b0);
      send_sample(24'hFFFFFF, 24'h000001, 1'b0);
      // missing frame_start: raster count wraps to row 0
      send_sample(24'h123456, 24'h654321, 1'b0);
      send_sample(24'h800000, 24'h7FFFFF, 1'b0);
      wait_drained();
      // clamped sizes, zero coefficients, most negative coupling
      set_grid(0, 0, 0, 0, 32'h8000_0000);
      send_frame(12);
      wait_drained();
   endtask

   // oversized column count clamps to the full line width: one full row, then wrap
   task automatic test_wide_grid();
      set_grid(2047, 3, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000);
      send_frame(NCOLS + 256);
      wait_drained();
   endtask

   // huge row count: interior rows keep coming, last row never reached
   task automatic test_tall_grid();
      set_grid(5, 65535, $urandom(), $urandom(), $urandom());
      send_frame(40);
      wait_drained();
   endtask

   // random small grids, mostly whole frames, some broken ones
   task automatic test_random_frames();
      int unsigned cols, rows, count;
      while (items_sent < 1900) begin
         cols = ($urandom_range(9) == 0) ? $urandom_range(64, 3) : $urandom_range(10, 3);
         rows = $urandom_range(8, 3);
         set_grid(cols, rows, $urandom_range(3) == 0 ? $urandom() : $urandom_range(262144),
                  $urandom_range(3) == 0 ? $urandom() : $urandom_range(262144),
                  $urandom_range(3) == 0 ? $urandom() : $urandom_range(131071) - 65536);
         repeat ($urandom_range(3, 1)) begin
            count = cols * rows;
            if ($urandom_range(4) == 0) count = $urandom_range(cols * rows + cols, 1);
            for (int unsigned i = 0; i < count; i++)
               send_sample(random_sample(), random_sample(),
                           i == 0 || $urandom_range(199) == 0);
         end
         wait_drained();
      end
   endtask

   // result side: random pop gaps after each accepted beat
   int pop_hold = 0;
   logic popped = 1'b0;
   always @(negedge clock) begin
      int gap;
      if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop <= 1'b0;
      end else if (popped) begin
         gap = random_gap();
         pop_hold <= gap;
         rsp_pop <= (gap == 0);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin
      k_beat_type e;
      popped = !reset && rsp_pop && !rsp_empty;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_k.size() == 0) begin
            $display("%0t: unexpected result row %0d col %0d", $time,
                     rsp_out_row, rsp_out_col);
            error_count++;
         end else begin
            e = expected_k.pop_front();
            if (rsp_k_re !== e.k_re) begin
               $display("%0t: k_re expected %h actual %h", $time, e.k_re, rsp_k_re);
               error_count++;
            end
            if (rsp_k_im !== e.k_im) begin
               $display("%0t: k_im expected %h actual %h", $time, e.k_im, rsp_k_im);
               error_count++;
            end
            if (rsp_out_row !== e.row) begin
               $display("%0t: out_row expected %0d actual %0d", $time, e.row, rsp_out_row);
               error_count++;
            end
            if (rsp_out_col !== e.col) begin
               $display("%0t: out_col expected %0d actual %0d", $time, e.col, rsp_out_col);
               error_count++;
            end
            if (rsp_last_of_item !== e.last) begin
               $display("%0t: last_of_item expected %b actual %b", $time, e.last,
                        rsp_last_of_item);
               error_count++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < NCOLS; i++) begin
         upper_row[i] = '{0, 0};
         middle_row[i] = '{0, 0};
      end
      left_sample = '{0, 0};
      row_pos = 0;
      col_pos = 0;
      grid_cols_reg = 64;
      grid_rows_reg = 64;
      coef_x_reg = 32'h0001_0000;
      coef_y_reg = 32'h0001_0000;
      coupling_reg = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      // reset-value run before any register is written
      send_frame(70);
      wait_drained();
      test_directed_extremes();
      test_tall_grid();
      test_wide_grid();
      test_random_frames();
      wait_drained();
      if (error_count == 0 && expected_k.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/gprs_pkg.sv
rtl/gprs_ram.sv
rtl/gprs_front.sv
rtl/gprs_queue.sv
rtl/gprs_back.sv
rtl/gpe_real_time_rhs_stencil.sv
rtl/gprs_checker.sv
tb/sv/gpe_real_time_rhs_stencil_test.sv
